[sv/buffer_pool_directory_lru_unit_assert.svh]
// Assertion macros for the buffer pool directory.
// Included by the modules that carry concurrent checks; needs aclk and aresetn in scope.
`ifndef BUFFER_POOL_DIRECTORY_LRU_UNIT_ASSERT_SVH
`define BUFFER_POOL_DIRECTORY_LRU_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BPDLRU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("buffer pool directory check failed");

// Next-cycle implication, disabled during reset
`define BPDLRU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("buffer pool directory check failed");

`endif

[sv/bpdlru_pkg.sv]
// Shared types and constants of the buffer pool directory.
// No dependencies; used by bpdlru_scan and buffer_pool_directory_lru_unit.
package bpdlru_pkg;

    localparam int FUNC_W   = 2;
    localparam int FILE_W   = 8;
    localparam int BLOCK_W  = 16;
    localparam int INDEX_W  = 6;
    localparam int ENTRY_W  = 6;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // Request operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_GET   = 2'd0,
        FN_MARK  = 2'd1,
        FN_INVAL = 2'd2,
        FN_ALLOC = 2'd3
    } func_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Outcome of one directory sweep
    typedef struct packed {
        logic match_found;
        logic free_found;
        logic have_victim;
    } scan_flags_t;

endpackage

[sv/bpdlru_scan.sv]
// Directory sweep unit: compares one entry per cycle and tracks the first match,
// the first free entry and the oldest entry of another file. Uses bpdlru_pkg.
module bpdlru_scan #(
    parameter int IDX_W      = 6,
    parameter int STAMP_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          eval_vld,
    input  logic [IDX_W-1:0]              eval_idx,
    input  logic                          ent_valid,
    input  logic [bpdlru_pkg::FILE_W-1:0]  ent_file,
    input  logic [bpdlru_pkg::BLOCK_W-1:0] ent_block,
    input  logic [STAMP_BITS-1:0]         ent_stamp,
    input  logic [bpdlru_pkg::FILE_W-1:0]  req_file,
    input  logic [bpdlru_pkg::BLOCK_W-1:0] req_block,
    output logic                          file_eq,
    output bpdlru_pkg::scan_flags_t       flags,
    output logic [IDX_W-1:0]              match_idx,
    output logic [IDX_W-1:0]              free_idx,
    output logic [IDX_W-1:0]              best_idx,
    output logic [bpdlru_pkg::FILE_W-1:0]  best_file,
    output logic [bpdlru_pkg::BLOCK_W-1:0] best_block
);
    import bpdlru_pkg::*;

    scan_flags_t             flags_reg, flags_next;
    logic [IDX_W-1:0]        match_idx_reg, free_idx_reg, best_idx_reg;
    logic [FILE_W-1:0]       best_file_reg;
    logic [BLOCK_W-1:0]      best_block_reg;
    logic [STAMP_BITS-1:0]   best_stamp_reg;
    logic                    blk_eq, older;
    logic                    take_match, take_free, take_best;

    // Shared compare unit
    assign file_eq = (ent_file == req_file);
    assign blk_eq  = (ent_block == req_block);
    assign older   = (ent_stamp < best_stamp_reg);

    // Tracker update decisions; entry 0 always seeds the victim
    assign take_match = eval_vld && ent_valid && file_eq && blk_eq && !flags_reg.match_found;
    assign take_free  = eval_vld && !ent_valid && !flags_reg.free_found;
    assign take_best  = eval_vld && ((eval_idx == '0) ||
                        (!file_eq && (!flags_reg.have_victim || older)));

    always_comb begin
        flags_next = flags_reg;
        if (start) begin
            flags_next = '0;
        end else begin
            if (take_match) flags_next.match_found = 1'b1;
            if (take_free)  flags_next.free_found  = 1'b1;
            if (take_best)  flags_next.have_victim = flags_reg.have_victim | !file_eq;
        end
    end

    // Flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    // Tracked indexes and victim payload
    always_ff @(posedge aclk) begin
        if (!start) begin
            if (take_match) match_idx_reg <= eval_idx;
            if (take_free)  free_idx_reg  <= eval_idx;
            if (take_best) begin
                best_idx_reg   <= eval_idx;
                best_file_reg  <= ent_file;
                best_block_reg <= ent_block;
                best_stamp_reg <= ent_stamp;
            end
        end
    end

    assign flags      = flags_reg;
    assign match_idx  = match_idx_reg;
    assign free_idx   = free_idx_reg;
    assign best_idx   = best_idx_reg;
    assign best_file  = best_file_reg;
    assign best_block = best_block_reg;

endmodule

[sv/buffer_pool_directory_lru_unit.sv]
// Get, allocate and invalidate sweep the directory one entry per cycle through the shared
// compare unit and then load the result in the finish step; a mark write goes straight there.
// One item at a time: requests are taken only in idle, and the finish step also waits
// while the previous result still waits on m_tready.
// Reset (aresetn low, synchronous) clears valid/dirty bits, tick counter, sequencer and
// output; file, block and stamp memories are not cleared. Uses bpdlru_pkg and bpdlru_scan.
module buffer_pool_directory_lru_unit #(
    parameter int ENTRIES    = 64,
    parameter int STAMP_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // func[1:0], file_id[9:2], block_offset[25:10], entry_index[31:26]
    input  logic [bpdlru_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // entry[5:0], hit[6], writeback[7], victim_file[15:8], victim_offset[31:16]
    output logic [bpdlru_pkg::M_TDATA_W-1:0]  m_tdata
);
    import bpdlru_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    // Sequencer and request
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    func_t                func_reg;
    logic [FILE_W-1:0]    file_reg;
    logic [BLOCK_W-1:0]   blk_reg;
    logic [INDEX_W-1:0]   idx_reg;
    logic                 accept, scan_start, res_load;

    // Directory storage
    logic [FILE_W+BLOCK_W-1:0] meta_mem [ENTRIES];
    logic [STAMP_BITS-1:0]     stamp_mem [ENTRIES];
    logic [FILE_W+BLOCK_W-1:0] meta_rd_reg;
    logic [STAMP_BITS-1:0]     stamp_rd_reg;
    logic [ENTRIES-1:0]        valid_reg, dirty_reg;
    logic [STAMP_BITS-1:0]     tick_count_reg;
    logic [STAMP_BITS-1:0]     tick_inc;
    logic [IDX_W-1:0]          rd_addr;
    logic                      eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]          eval_idx_reg;

    // Finish-step decisions
    logic                  meta_we, stamp_we, valid_set;
    logic [IDX_W-1:0]      wr_addr;
    logic                  wr_dirty;
    logic                  mark_ok;
    logic [IDX_W+INDEX_W-1:0] idx_ext;
    logic [IDX_W-1:0]      idx_trunc;
    logic                  hit_sel, wb_sel;
    logic [IDX_W-1:0]      slot_sel;
    logic [IDX_W+ENTRY_W-1:0] slot_ext;
    logic [ENTRY_W-1:0]    entry_out;
    logic [M_TDATA_W-1:0]  result;

    // Sweep unit outputs
    logic                  file_eq;
    scan_flags_t           flags;
    logic [IDX_W-1:0]      match_idx, free_idx, best_idx;
    logic [FILE_W-1:0]     best_file;
    logic [BLOCK_W-1:0]    best_block;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_addr  = cnt_reg[IDX_W-1:0];
    assign tick_inc = tick_count_reg + 1'b1;

    // Mark write range check and index width fit
    assign idx_ext   = {{IDX_W{1'b0}}, idx_reg};
    assign idx_trunc = idx_ext[IDX_W-1:0];
    assign mark_ok   = ({{(IDX_W+1){1'b0}}, idx_reg} < (IDX_W+INDEX_W+1)'(ENTRIES));

    // Slot choice after the sweep
    always_comb begin
        hit_sel = (func_reg == FN_GET) && flags.match_found;
        if (hit_sel) begin
            slot_sel = match_idx;
        end else if (flags.free_found) begin
            slot_sel = free_idx;
        end else begin
            slot_sel = best_idx;
        end
        wb_sel = ((func_reg == FN_GET) || (func_reg == FN_ALLOC)) && !hit_sel &&
                 !flags.free_found && dirty_reg[best_idx];
    end

    assign slot_ext = {{ENTRY_W{1'b0}}, slot_sel};

    // Result field selection
    always_comb begin
        unique case (func_reg)
            FN_GET, FN_ALLOC: entry_out = slot_ext[ENTRY_W-1:0];
            FN_MARK:          entry_out = idx_reg;
            FN_INVAL:         entry_out = '0;
            default:          entry_out = '0;
        endcase
        result = {(wb_sel ? best_block : {BLOCK_W{1'b0}}),
                  (wb_sel ? best_file : {FILE_W{1'b0}}),
                  wb_sel, hit_sel, entry_out};
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            eval_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            eval_vld_reg <= eval_vld_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        eval_vld_next = 1'b0;
        scan_start    = 1'b0;
        res_load      = 1'b0;
        meta_we       = 1'b0;
        stamp_we      = 1'b0;
        valid_set     = 1'b0;
        wr_addr       = slot_sel;
        wr_dirty      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cnt_next   = '0;
                    scan_start = 1'b1;
                    if (func_t'(s_tdata[FUNC_W-1:0]) == FN_MARK) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (cnt_reg == CNT_W'(ENTRIES)) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next      = cnt_reg + 1'b1;
                    eval_vld_next = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                    priority if (func_reg == FN_MARK) begin
                        wr_addr  = idx_trunc;
                        stamp_we = mark_ok;
                        wr_dirty = 1'b1;
                    end else if (func_reg == FN_ALLOC || (func_reg == FN_GET && !hit_sel)) begin
                        meta_we   = 1'b1;
                        stamp_we  = 1'b1;
                        valid_set = 1'b1;
                        wr_dirty  = (func_reg == FN_ALLOC);
                    end else begin
                        wr_dirty = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= func_t'(s_tdata[FUNC_W-1:0]);
            file_reg <= s_tdata[FUNC_W +: FILE_W];
            blk_reg  <= s_tdata[FUNC_W+FILE_W +: BLOCK_W];
            idx_reg  <= s_tdata[FUNC_W+FILE_W+BLOCK_W +: INDEX_W];
        end
    end

    // Directory memories: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (meta_we) meta_mem[wr_addr] <= {blk_reg, file_reg};
        if (stamp_we) stamp_mem[wr_addr] <= tick_count_reg;
        meta_rd_reg  <= meta_mem[rd_addr];
        stamp_rd_reg <= stamp_mem[rd_addr];
        eval_idx_reg <= rd_addr;
    end

    // Valid and dirty bits, tick counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            dirty_reg      <= '0;
            tick_count_reg <= '0;
        end else begin
            if (eval_vld_reg && func_reg == FN_INVAL && file_eq) begin
                valid_reg[eval_idx_reg] <= 1'b0;
                dirty_reg[eval_idx_reg] <= 1'b0;
            end
            if (valid_set) valid_reg[wr_addr] <= 1'b1;
            if (stamp_we) dirty_reg[wr_addr] <= wr_dirty;
            if (res_load) tick_count_reg <= tick_inc;
        end
    end

    bpdlru_scan #(
        .IDX_W      (IDX_W),
        .STAMP_BITS (STAMP_BITS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (scan_start),
        .eval_vld   (eval_vld_reg),
        .eval_idx   (eval_idx_reg),
        .ent_valid  (valid_reg[eval_idx_reg]),
        .ent_file   (meta_rd_reg[FILE_W-1:0]),
        .ent_block  (meta_rd_reg[FILE_W +: BLOCK_W]),
        .ent_stamp  (stamp_rd_reg),
        .req_file   (file_reg),
        .req_block  (blk_reg),
        .file_eq    (file_eq),
        .flags      (flags),
        .match_idx  (match_idx),
        .free_idx   (free_idx),
        .best_idx   (best_idx),
        .best_file  (best_file),
        .best_block (best_block)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) m_tdata_reg <= result;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "buffer_pool_directory_lru_unit_assert.svh"

    `BPDLRU_ASSERT_NXT(a_accept_leaves_idle, accept, state_reg != ST_IDLE)
    `BPDLRU_ASSERT_IMP(a_scan_count_bound, state_reg == ST_SCAN, cnt_reg <= CNT_W'(ENTRIES))
    `BPDLRU_ASSERT_IMP(a_no_wb_with_free, res_load && flags.free_found, !wb_sel)
    `BPDLRU_ASSERT_IMP(a_no_wb_on_hit, res_load && hit_sel, !wb_sel && !meta_we)
    `BPDLRU_ASSERT_NXT(a_tick_per_result, res_load, tick_count_reg == $past(tick_inc))

endmodule
